// File: src/xrg_pkg.sv
// Shared constants and types for the xorshift128 range generator.
`default_nettype none
package xrg_pkg;

	localparam int WORD_W = 32;
	localparam int CNT_W  = $clog2(WORD_W);

	typedef logic [WORD_W-1:0] word_t;

	localparam word_t START_X = 32'd123456789;
	localparam word_t START_Y = 32'd362436069;
	localparam word_t START_Z = 32'd521288629;
	localparam word_t START_W = 32'd88675123;

	localparam int SHIFT_A = 11;
	localparam int SHIFT_B = 19;
	localparam int SHIFT_C = 8;

	// Configuration register indexes
	localparam logic REG_SEED_LOW  = 1'b0;
	localparam logic REG_SEED_HIGH = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_LOAD = 4'b0010,
		ST_DIV  = 4'b0100,
		ST_DONE = 4'b1000
	} state_t;

endpackage
`default_nettype wire

// File: src/xrg_state.sv
// Generator state words with seeding and one-step advance.
`default_nettype none
module xrg_state (
	input  wire           clk,
	input  wire           arst_n,
	input  wire           step,
	input  xrg_pkg::word_t seed_low,
	input  xrg_pkg::word_t seed_high,
	output xrg_pkg::word_t gen_w
);
	import xrg_pkg::*;

	word_t gen_x_q, gen_y_q, gen_z_q, gen_w_q;
	logic  seeded_q;
	word_t src_x, src_y, src_z, src_w, t, nw;

	// Load start values on the first step after reset
	always_comb begin
		src_x = seeded_q ? gen_x_q : START_X;
		src_y = seeded_q ? gen_y_q : (START_Y ^ seed_low);
		src_z = seeded_q ? gen_z_q : START_Z;
		src_w = seeded_q ? gen_w_q : (START_W ^ seed_high);
		t     = src_x ^ (src_x << SHIFT_A);
		nw    = src_w ^ (src_w >> SHIFT_B) ^ t ^ (t >> SHIFT_C);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gen_x_q  <= '0;
			gen_y_q  <= '0;
			gen_z_q  <= '0;
			gen_w_q  <= '0;
			seeded_q <= 1'b0;
		end else if (step) begin
			gen_x_q  <= src_y;
			gen_y_q  <= src_z;
			gen_z_q  <= src_w;
			gen_w_q  <= nw;
			seeded_q <= 1'b1;
		end
	end

	assign gen_w = gen_w_q;
endmodule
`default_nettype wire

// File: src/xrg_div.sv
// Restoring remainder unit, one dividend bit per cycle.
`default_nettype none
module xrg_div (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            start,
	input  xrg_pkg::word_t dividend,
	input  xrg_pkg::word_t divisor,
	output logic           done,
	output xrg_pkg::word_t remainder
);
	import xrg_pkg::*;

	word_t              rem_q, num_q, den_q;
	logic [CNT_W-1:0]   count_q;
	logic               busy_q;
	logic [WORD_W:0]    partial, trial;

	always_comb begin
		partial = {rem_q, num_q[WORD_W-1]};
		trial   = partial - {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			count_q <= '0;
		end else if (start) begin
			busy_q  <= 1'b1;
			count_q <= '0;
		end else if (busy_q) begin
			count_q <= count_q + 1'b1;
			if (count_q == CNT_W'(WORD_W - 1)) busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			num_q <= dividend;
			den_q <= divisor;
		end else if (busy_q) begin
			// Keep the trial difference when it does not borrow
			rem_q <= trial[WORD_W] ? partial[WORD_W-1:0] : trial[WORD_W-1:0];
			num_q <= {num_q[WORD_W-2:0], 1'b0};
		end
	end

	assign done      = busy_q && (count_q == CNT_W'(WORD_W - 1));
	assign remainder = rem_q;
endmodule
`default_nettype wire

// File: src/xorshift128_range_generator.sv
// Top level of the xorshift128 range generator: sequencer, seeds and output register.
//
// Usage:
//   Input channel (in_valid / in_stall / modulus): each transaction is one draw
//   request. The generator advances one xorshift128 step in the accept cycle;
//   the first draw after reset first loads the start words, with seed_low
//   XORed into y and seed_high into w.
//   Output channel (out_valid / out_stall / value / bad_modulus): one
//   transaction per draw, holding the new w word modulo modulus. A zero
//   modulus returns value 0 with bad_modulus set and skips the divider.
//   Config port (wr_en / wr_index / wr_data): index 0 is seed_low, 1 is
//   seed_high. Seeds only matter at the first draw after reset.
// Timing:
//   A draw runs through accept, divider load, the remainder iterations
//   of the restoring unit and result hand-off; a zero modulus goes from
//   accept straight to result hand-off. in_stall is high whenever the
//   sequencer is not idle, from after the accept until the hand-off.
//   The output register lets a new request be accepted while the previous
//   result still waits; a finished result waits in the sequencer while
//   out_stall holds the older one.
// Reset: asynchronous active-low arst_n clears seeds, state words, the
//   sequencer and out_valid.
`default_nettype none
module xorshift128_range_generator (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            in_valid,
	output logic           in_stall,
	input  xrg_pkg::word_t modulus,
	output logic           out_valid,
	input  wire            out_stall,
	output xrg_pkg::word_t value,
	output logic           bad_modulus,
	input  wire            wr_en,
	input  wire            wr_index,
	input  xrg_pkg::word_t wr_data
);
	import xrg_pkg::*;

	state_t state_q;
	word_t  seed_low_q, seed_high_q, modulus_q, result_q, gen_w;
	logic   bad_q, accept, div_done, load_out;
	word_t  remainder;

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;
	// Hand the result over once the output register is free or draining
	assign load_out = (state_q == ST_DONE) && (!out_valid || !out_stall);

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_low_q  <= '0;
			seed_high_q <= '0;
		end else if (wr_en) begin
			case (wr_index)
				REG_SEED_LOW:  seed_low_q  <= wr_data;
				REG_SEED_HIGH: seed_high_q <= wr_data;
				default: ;
			endcase
		end
	end

	xrg_state u_state (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (accept),
		.seed_low  (seed_low_q),
		.seed_high (seed_high_q),
		.gen_w     (gen_w)
	);

	xrg_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (state_q == ST_LOAD),
		.dividend  (gen_w),
		.divisor   (modulus_q),
		.done      (div_done),
		.remainder (remainder)
	);

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: if (accept) begin
					// Zero modulus skips the divider
					state_q <= (modulus == '0) ? ST_DONE : ST_LOAD;
				end
				ST_LOAD: state_q <= ST_DIV;
				ST_DIV:  if (div_done) state_q <= ST_DONE;
				ST_DONE: if (load_out) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Request capture and result hold
	always_ff @(posedge clk) begin
		if (accept) begin
			modulus_q <= modulus;
			bad_q     <= (modulus == '0);
		end
		if (load_out) begin
			result_q    <= bad_q ? '0 : remainder;
			bad_modulus <= bad_q;
		end
	end

	assign value = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (load_out) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end
endmodule
`default_nettype wire

// File: src/xrg_checker.sv
// Port-level checks for the xorshift128 range generator, bound to the top level.
`default_nettype none
module xrg_checker (
	input wire            clk,
	input wire            arst_n,
	input wire            in_valid,
	input wire            in_stall,
	input wire            out_valid,
	input wire            out_stall,
	input xrg_pkg::word_t value,
	input wire            bad_modulus
);
	// Hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(value) && $stable(bad_modulus))
		else $error("stalled result changed");

	// A flagged result carries zero
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && bad_modulus |-> value == '0)
		else $error("bad modulus with nonzero value");

	// Stay busy for the cycle after a draw is accepted
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("request accepted too early");

	// A new result leaves a busy sequencer
	a_result_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared without a pending draw");
endmodule

bind xorshift128_range_generator xrg_checker u_xrg_checker (.*);
`default_nettype wire
